// ===== design/bvd_pkg.sv =====
// Shared types, constants and helper functions for the binary vector distance block.
package bvd_pkg;

  localparam int LANES    = 32;
  localparam int LANE_W   = $clog2(LANES + 1);
  localparam int CNT_W    = 21;
  localparam int MAX_BITS = 1048576;
  localparam int FRAC_W   = 16;
  localparam int DIST_W   = FRAC_W + 1;
  localparam int SUM_W    = CNT_W + 1;
  localparam int REM_W    = SUM_W + 1;
  localparam int STEP_W   = $clog2(DIST_W);
  localparam int METRIC_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BITS);

  localparam logic [METRIC_W-1:0] METRIC_DICE    = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_XOR_CNT = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_HAMMING = 2'd2;

  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    logic [CNT_W-1:0]    and_cnt;
    logic [CNT_W-1:0]    ones_x;
    logic [CNT_W-1:0]    ones_y;
    logic [CNT_W-1:0]    diff;
    logic [CNT_W-1:0]    bits;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_OUT
  } back_state_t;

  function automatic logic [LANE_W-1:0] popcount(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] n;
    n = '0;
    for (int i = 0; i < LANES; i++) begin
      n = n + LANE_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                input logic [LANE_W-1:0] inc);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(acc) + SUM_W'(inc);
    if (sum > SUM_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return sum[CNT_W-1:0];
  endfunction

endpackage

// ===== design/binary_vector_distance.sv =====
// Top level: Dice / Hamming distance between two streamed bit sequences.
// Throughput: one 32-bit word pair per cycle; in_ready drops only while both queue slots hold jobs.
// Path: the last word pushes a job into the queue; the back end pops it, sets up the operands,
// runs the serial divider unless the ratio is zero or unused, and holds the result in ST_OUT.
// The two-job queue hides short sequences while the back end is busy.
// Synchronous active-high reset clears the counts, the queue, the back end and metric (Dice).
module binary_vector_distance import bvd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LANES-1:0]    x_bits,
  input  logic [LANES-1:0]    y_bits,
  input  logic [LANE_W-1:0]   valid_count,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DIST_W-1:0]   distance_q16,
  output logic [CNT_W-1:0]    difference_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [METRIC_W-1:0] cfg_data
);

  logic q_push, q_pop, q_full, q_empty;
  job_t q_in, q_out;

  bvd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_bits      (x_bits),
    .y_bits      (y_bits),
    .valid_count (valid_count),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  bvd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  bvd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .distance_q16     (distance_q16),
    .difference_count (difference_count)
  );

endmodule

// ===== design/bvd_front.sv =====
// Front end: accepts bit words, keeps the running counts, queues a job on the last word.
module bvd_front import bvd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LANES-1:0]    x_bits,
  input  logic [LANES-1:0]    y_bits,
  input  logic [LANE_W-1:0]   valid_count,
  input  logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [METRIC_W-1:0] cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output job_t                q_data
);

  logic [METRIC_W-1:0] metric;
  logic [CNT_W-1:0]    and_cnt, ones_x, ones_y, diff, bits;
  logic [LANE_W-1:0]   n;
  logic [LANES-1:0]    mask, xm, ym;
  logic                accept;
  job_t                upd;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && last;

  always_comb begin
    n = (valid_count > LANE_W'(LANES)) ? LANE_W'(LANES) : valid_count;
    for (int i = 0; i < LANES; i++) begin
      mask[i] = (LANE_W'(i) < n);
    end
    xm = x_bits & mask;
    ym = y_bits & mask;
    upd.metric  = metric;
    upd.and_cnt = sat_add(and_cnt, popcount(xm & ym));
    upd.ones_x  = sat_add(ones_x, popcount(xm));
    upd.ones_y  = sat_add(ones_y, popcount(ym));
    upd.diff    = sat_add(diff, popcount(xm ^ ym));
    upd.bits    = sat_add(bits, n);
    q_data      = upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metric  <= METRIC_DICE;
      and_cnt <= '0;
      ones_x  <= '0;
      ones_y  <= '0;
      diff    <= '0;
      bits    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        metric <= cfg_data;
      end
      if (accept) begin
        if (last) begin
          and_cnt <= '0;
          ones_x  <= '0;
          ones_y  <= '0;
          diff    <= '0;
          bits    <= '0;
        end else begin
          and_cnt <= upd.and_cnt;
          ones_x  <= upd.ones_x;
          ones_y  <= upd.ones_y;
          diff    <= upd.diff;
          bits    <= upd.bits;
        end
      end
    end
  end

endmodule

// ===== design/bvd_queue.sv =====
// Two-entry job queue between the front end and the divider back end.
module bvd_queue import bvd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/bvd_back.sv =====
// Back end: picks the ratio operands and runs a one-bit-per-cycle restoring divider.
module bvd_back import bvd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  job_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] distance_q16,
  output logic [CNT_W-1:0]  difference_count
);

  back_state_t       state, state_next;
  job_t              job;
  logic [REM_W-1:0]  rem, trial;
  logic [SUM_W-1:0]  den, s, twice, num;
  logic [DIST_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic              zero;

  always_comb begin
    s     = SUM_W'(job.ones_x) + SUM_W'(job.ones_y);
    twice = {job.and_cnt, 1'b0};
    unique case (job.metric)
      METRIC_DICE: begin
        zero = (job.bits == '0) || (s == '0) || (twice > s);
        num  = s - twice;
      end
      METRIC_HAMMING: begin
        zero = (job.bits == '0);
        num  = SUM_W'(job.diff);
      end
      default: begin
        zero = 1'b1;
        num  = '0;
      end
    endcase
    trial = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = zero ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(DIST_W - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        job <= q_data;
      end
      ST_SETUP: begin
        rem  <= REM_W'(num);
        den  <= (job.metric == METRIC_DICE) ? s : SUM_W'(job.bits);
        quo  <= '0;
        step <= '0;
        difference_count <= job.diff;
        distance_q16     <= '0;
      end
      ST_DIV: begin
        if (trial >= REM_W'(den)) begin
          rem <= trial - REM_W'(den);
          quo <= {quo[DIST_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[DIST_W-2:0], 1'b0};
        end
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIST_W - 1)) begin
          distance_q16 <= {quo[DIST_W-2:0], (trial >= REM_W'(den))};
        end
      end
      default: begin
        job <= job;
      end
    endcase
  end

endmodule

// ===== design/bvd_checker.sv =====
// Port-level checks for binary_vector_distance, bound to the top level.
module bvd_checker import bvd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DIST_W-1:0]   distance_q16,
  input logic [CNT_W-1:0]    difference_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_q16)
                                && $stable(difference_count))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_q16 <= DIST_W'(1 << FRAC_W))
    else $error("ratio above one");

  a_diff_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> difference_count <= CNT_MAX)
    else $error("difference count above saturation");

  // back end passes through ST_IDLE and ST_SETUP between result words
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid ##1 !out_valid)
    else $error("result words closer than the back end allows");

endmodule

bind binary_vector_distance bvd_checker u_bvd_checker (.*);

// ===== dv/tb_binary_vector_distance.sv =====
// Testbench for binary_vector_distance: checks every result against a predictor.
`timescale 1ns / 1ps

module tb_binary_vector_distance import bvd_pkg::*; ();

  localparam logic [METRIC_W-1:0] METRIC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS = 225;

  typedef struct packed {
    logic [DIST_W-1:0] ratio;
    logic [CNT_W-1:0]  diff;
  } distance_t;

  class distance_tracker;
    int unsigned and_hits, ones_x, ones_y, diff_hits, bit_len;
    logic [METRIC_W-1:0] metric;
    distance_t pending_distances[$];
    int unsigned failures, results_seen;
    int unsigned seqs_by_metric[4];

    function new();
      metric = METRIC_DICE;
      clear_counts();
    endfunction

    function void clear_counts();
      and_hits = 0;
      ones_x = 0;
      ones_y = 0;
      diff_hits = 0;
      bit_len = 0;
    endfunction

    function int unsigned sat(int unsigned acc, int unsigned inc);
      return (acc + inc > MAX_BITS) ? MAX_BITS : acc + inc;
    endfunction

    function void note_word(logic [LANES-1:0] x, logic [LANES-1:0] y,
                            logic [LANE_W-1:0] vc, logic lst);
      int unsigned n;
      logic [LANES-1:0] mask, xm, ym;
      logic [63:0] s, twice, q;
      distance_t r;
      n = (vc > LANES) ? LANES : vc;
      mask = (n == LANES) ? '1 : ((32'd1 << n) - 32'd1);
      xm = x & mask;
      ym = y & mask;
      and_hits = sat(and_hits, $countones(xm & ym));
      ones_x = sat(ones_x, $countones(xm));
      ones_y = sat(ones_y, $countones(ym));
      diff_hits = sat(diff_hits, $countones(xm ^ ym));
      bit_len = sat(bit_len, n);
      if (!lst) return;
      q = '0;
      case (metric)
        METRIC_DICE: begin
          s = 64'(ones_x) + 64'(ones_y);
          twice = 64'(and_hits) * 2;
          if (bit_len != 0 && s != 0 && twice <= s) q = ((s - twice) << FRAC_W) / s;
        end
        METRIC_HAMMING: begin
          if (bit_len != 0) q = (64'(diff_hits) << FRAC_W) / 64'(bit_len);
        end
        default: ;
      endcase
      r.ratio = q[DIST_W-1:0];
      r.diff = diff_hits[CNT_W-1:0];
      pending_distances.push_back(r);
      seqs_by_metric[metric]++;
      clear_counts();
    endfunction

    function void check_distance(logic [DIST_W-1:0] ratio, logic [CNT_W-1:0] diff);
      distance_t want;
      bit ratio_bad, diff_bad;
      results_seen++;
      if (pending_distances.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result %0d: distance_q16 %0d difference_count %0d",
                   results_seen, ratio, diff);
        return;
      end
      want = pending_distances.pop_front();
      ratio_bad = (ratio !== want.ratio);
      diff_bad = (diff !== want.diff);
      if (ratio_bad || diff_bad) begin
        failures++;
        if (failures <= 10)
          $display("Mismatch on result %0d: distance_q16 exp %0d got %0d, %s%0d got %0d",
                   results_seen, want.ratio, ratio, "difference_count exp ", want.diff, diff);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [LANES-1:0] x_bits = '0;
  logic [LANES-1:0] y_bits = '0;
  logic [LANE_W-1:0] valid_count = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] distance_q16;
  logic [CNT_W-1:0] difference_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [METRIC_W-1:0] cfg_data = '0;

  distance_tracker tracker = new();
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_len = 0;
  int unsigned words_sent = 0;
  int unsigned longest_stall = 0;
  logic [METRIC_W-1:0] metric_plan[RANDOM_PHASES] = '{METRIC_XOR_CNT, METRIC_DICE,
      METRIC_HAMMING, METRIC_UNUSED, METRIC_DICE, METRIC_HAMMING, METRIC_XOR_CNT,
      METRIC_HAMMING};

  binary_vector_distance i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .x_bits           (x_bits),
    .y_bits           (y_bits),
    .valid_count      (valid_count),
    .last             (last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .distance_q16     (distance_q16),
    .difference_count (difference_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tracker.check_distance(distance_q16, difference_count);
      if (hold_len != 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    int unsigned quiet, stall;
    quiet = 0;
    stall = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (in_valid && !in_ready) begin
        stall++;
        if (stall > longest_stall) longest_stall = stall;
      end else begin
        stall = 0;
      end
    end
    $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [LANES-1:0] x, input logic [LANES-1:0] y,
                           input logic [LANE_W-1:0] vc, input logic lst);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_bits <= x;
    y_bits <= y;
    valid_count <= vc;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_word(x, y, vc, lst);
    words_sent++;
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_metric(input logic [METRIC_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.metric = m;
  endtask

  task automatic run_directed();
    send_word('1, '1, 6'd0, 1'b1);
    send_word('0, '0, 6'd32, 1'b1);
    send_word('1, '1, 6'd63, 1'b1);
    send_word('1, '0, 6'd32, 1'b1);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 6'd40, 1'b1);
    send_word(32'hFFFF_0000, 32'h0000_FFFF, 6'd16, 1'b0);
    send_word(32'h1234_5678, 32'h8765_4321, 6'd31, 1'b0);
    send_word(32'h8000_0001, 32'h0000_0001, 6'd1, 1'b1);
    send_word(32'h0000_FFFF, 32'hFFFF_0000, 6'd33, 1'b0);
    send_word('0, '1, 6'd0, 1'b0);
    send_word(32'hC3C3_C3C3, 32'hC3C3_C3C3, 6'd48, 1'b1);
  endtask

  task automatic send_random_sequence();
    int unsigned len, pick;
    logic [LANES-1:0] x, y;
    logic [LANE_W-1:0] vc;
    pick = $urandom_range(9);
    len = (pick < 6) ? $urandom_range(4, 1) :
          (pick < 9) ? $urandom_range(16, 5) : $urandom_range(60, 17);
    for (int i = 0; i < len; i++) begin
      x = $urandom;
      y = $urandom;
      case ($urandom_range(9))
        0: begin x = '0; y = '0; end
        1: begin x = '1; y = '1; end
        2: y = x;
        3: y = ~x;
        4: begin x = x & $urandom & $urandom; y = y & $urandom & $urandom; end
        default: ;
      endcase
      vc = ($urandom_range(9) < 6) ? 6'd32 : 6'($urandom_range(63));
      send_word(x, y, vc, i == len - 1);
    end
  endtask

  initial begin
    int unsigned target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    end_phase();
    write_metric(METRIC_HAMMING);
    run_directed();
    end_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_metric(metric_plan[p]);
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 54; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 54; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_random_sequence();
      end_phase();
    end

    // long receiver hold-off so the job queue fills and backpressures the input
    write_metric(METRIC_DICE);
    send_idle = 0;
    recv_stall = 0;
    hold_len = HOLD_OFF_CYCLES;
    for (int i = 0; i < 60; i++) send_word($urandom, $urandom, 6'd32, 1'b1);
    end_phase();

    $display("Covered %0d words; sequences per metric: dice %0d, xor count %0d, %s%0d, %s%0d",
             words_sent, tracker.seqs_by_metric[METRIC_DICE],
             tracker.seqs_by_metric[METRIC_XOR_CNT], "hamming ",
             tracker.seqs_by_metric[METRIC_HAMMING], "unused ",
             tracker.seqs_by_metric[METRIC_UNUSED]);
    $display("Idle and stall mixes plus a receiver hold-off; longest input backpressure %0d cycles",
             longest_stall);
    if (tracker.failures == 0 && tracker.pending_distances.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures, %0d results missing", tracker.failures,
               tracker.pending_distances.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bvd_pkg.sv
design/bvd_front.sv
design/bvd_queue.sv
design/bvd_back.sv
design/binary_vector_distance.sv
design/bvd_checker.sv
dv/tb_binary_vector_distance.sv
